[rtl/ubx_pkg.sv]
package ubx_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic [1:0] STATUS_GOOD     = 2'd0;
	localparam logic [1:0] STATUS_BAD_CKA  = 2'd1;
	localparam logic [1:0] STATUS_BAD_CKB  = 2'd2;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  frame_class;
		logic [7:0]  msg_id;
		logic [15:0] frame_length;
		logic [1:0]  status;
		logic        last;
	} ubx_result_t;

endpackage

[rtl/ubx_fsm.sv]
module ubx_fsm #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	output logic                 res_valid,
	output ubx_pkg::ubx_result_t res
);
	import ubx_pkg::*;

	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

	localparam logic [2:0] PH_SYNC1   = 3'd0;
	localparam logic [2:0] PH_SYNC2   = 3'd1;
	localparam logic [2:0] PH_CLASS   = 3'd2;
	localparam logic [2:0] PH_ID      = 3'd3;
	localparam logic [2:0] PH_LENGTH  = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_CKA     = 3'd6;
	localparam logic [2:0] PH_CKB     = 3'd7;

	logic [2:0]    phase_q, phase_d;
	logic [7:0]    class_q, class_d;
	logic [7:0]    id_q, id_d;
	logic [15:0]   length_q, length_d;
	logic [CW-1:0] count_q, count_d;
	logic          len_hi_q, len_hi_d;
	logic [7:0]    sum_a_q, sum_a_d;
	logic [7:0]    sum_b_q, sum_b_d;
	logic [7:0]    sum_a_add, sum_b_add;
	logic [16:0]   count_inc;

	assign sum_a_add = sum_a_q + rx_byte;
	assign sum_b_add = sum_b_q + sum_a_add;
	assign count_inc = 17'(count_q) + 17'd1;

	always_comb begin
		phase_d   = phase_q;
		class_d   = class_q;
		id_d      = id_q;
		length_d  = length_q;
		count_d   = count_q;
		len_hi_d  = len_hi_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		res_valid = 1'b0;
		res.kind       = KIND_PAYLOAD;
		res.data_byte  = 8'd0;
		res.byte_index = 8'd0;
		res.status     = STATUS_GOOD;

		unique case (phase_q)
			PH_SYNC1: begin
				if (rx_byte == SYNC_FIRST) begin
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					sum_a_d = 8'd0;
					sum_b_d = 8'd0;
					phase_d = PH_CLASS;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_CLASS: begin
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				class_d = rx_byte;
				phase_d = PH_ID;
			end
			PH_ID: begin
				sum_a_d  = sum_a_add;
				sum_b_d  = sum_b_add;
				id_d     = rx_byte;
				len_hi_d = 1'b0;
				count_d  = '0;
				phase_d  = PH_LENGTH;
			end
			PH_LENGTH: begin
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				if (!len_hi_q) begin
					length_d = {8'd0, rx_byte};
					len_hi_d = 1'b1;
				end else begin
					length_d = {rx_byte, length_q[7:0]};
					len_hi_d = 1'b0;
					if (17'(length_d) > MAX_LEN) begin
						// drop oversize frame, report it
						phase_d    = PH_SYNC1;
						res_valid  = 1'b1;
						res.kind   = KIND_END;
						res.status = STATUS_TOO_LONG;
					end else if (length_d == 16'd0) begin
						phase_d = PH_CKA;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				sum_a_d        = sum_a_add;
				sum_b_d        = sum_b_add;
				res_valid      = 1'b1;
				res.data_byte  = rx_byte;
				res.byte_index = 8'(count_q);
				if (count_inc >= 17'(length_q)) begin
					count_d = '0;
					phase_d = PH_CKA;
				end else begin
					count_d = CW'(count_inc);
				end
			end
			PH_CKA: begin
				if (rx_byte != sum_a_q) begin
					phase_d    = PH_SYNC1;
					res_valid  = 1'b1;
					res.kind   = KIND_END;
					res.status = STATUS_BAD_CKA;
				end else begin
					phase_d = PH_CKB;
				end
			end
			PH_CKB: begin
				phase_d    = PH_SYNC1;
				res_valid  = 1'b1;
				res.kind   = KIND_END;
				res.status = (rx_byte == sum_b_q) ? STATUS_GOOD : STATUS_BAD_CKB;
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase

		res.frame_class  = class_d;
		res.msg_id       = id_d;
		res.frame_length = length_d;
		res.last         = res.kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			class_q  <= 8'd0;
			id_q     <= 8'd0;
			length_q <= 16'd0;
			count_q  <= '0;
			len_hi_q <= 1'b0;
			sum_a_q  <= 8'd0;
			sum_b_q  <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			class_q  <= class_d;
			id_q     <= id_d;
			length_q <= length_d;
			count_q  <= count_d;
			len_hi_q <= len_hi_d;
			sum_a_q  <= sum_a_d;
			sum_b_q  <= sum_b_d;
		end
	end

	a_payload_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> 17'(count_q) < 17'(length_q))
		else $error("payload count reached frame length");

	a_payload_length_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> length_q != 16'd0 && 17'(length_q) <= MAX_LEN)
		else $error("payload phase with illegal length");

	a_end_resyncs: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res.kind == KIND_END |=> phase_q == PH_SYNC1)
		else $error("end of frame did not return to sync search");

	a_payload_only_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res.kind == KIND_PAYLOAD |-> phase_q == PH_PAYLOAD)
		else $error("payload byte emitted outside payload phase");

endmodule

[rtl/ubx_frame_parser.sv]
// UBX frame parser: takes one received byte per request and finds frames of the form
// 0xB5 0x62, class, id, 16-bit little-endian length, payload, CK_A, CK_B. Each payload
// byte comes out as it arrives (kind 0, with its index), and every frame that gets past
// its length field ends with one end-of-frame result (kind 1, last 1) whose status is
// good, CK_A bad, CK_B bad, or too long (length above MAX_PAYLOAD). For each accepted
// byte the parser state and Fletcher sums update on the accepting edge and any result
// lands in a single output register, so a new byte is taken every cycle unless that
// register holds a result the sink is stalling; each result shows in the next cycle.
module ubx_frame_parser #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  byte_index,
	output logic [7:0]  frame_class,
	output logic [7:0]  msg_id,
	output logic [15:0] frame_length,
	output logic [1:0]  status,
	output logic        last
);
	import ubx_pkg::*;

	logic        accept;
	logic        res_valid;
	ubx_result_t res;
	ubx_result_t out_q;
	logic        out_valid_q;

	// hold input only while a result waits on a stalled sink
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	ubx_fsm #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign data_byte    = out_q.data_byte;
	assign byte_index   = out_q.byte_index;
	assign frame_class  = out_q.frame_class;
	assign msg_id       = out_q.msg_id;
	assign frame_length = out_q.frame_length;
	assign status       = out_q.status;
	assign last         = out_q.last;

endmodule

[tb/sv/testbench.sv]
typedef enum logic [2:0] {
	PH_SYNC1,
	PH_SYNC2,
	PH_CLASS,
	PH_ID,
	PH_LENGTH,
	PH_PAYLOAD,
	PH_CKA,
	PH_CKB
} parse_phase_e;

class frame_scoreboard #(int MAX_LEN = 256);
	parse_phase_e phase;
	logic [7:0] cls;
	logic [7:0] id;
	logic [7:0] sum_a;
	logic [7:0] sum_b;
	logic [15:0] len;
	logic [15:0] count;
	ubx_pkg::ubx_result_t frame_results_q[$];
	int errors;

	function new();
		phase = PH_SYNC1;
		cls = '0;
		id = '0;
		sum_a = '0;
		sum_b = '0;
		len = '0;
		count = '0;
		errors = 0;
	endfunction

	function int pending();
		return frame_results_q.size();
	endfunction

	function void add_sum(logic [7:0] b);
		sum_a = sum_a + b;
		sum_b = sum_b + sum_a;
	endfunction

	function void emit(logic k, logic [7:0] data, logic [7:0] idx, logic [1:0] st);
		ubx_pkg::ubx_result_t r;
		r.kind = k;
		r.data_byte = data;
		r.byte_index = idx;
		r.frame_class = cls;
		r.msg_id = id;
		r.frame_length = len;
		r.status = st;
		r.last = k;
		frame_results_q.push_back(r);
	endfunction

	// Advance the frame parse by one accepted byte and queue what it produces.
	function void note_byte(logic [7:0] b);
		case (phase)
			PH_SYNC1: begin
				if (b == ubx_pkg::SYNC_FIRST)
					phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (b == ubx_pkg::SYNC_SECOND) begin
					sum_a = '0;
					sum_b = '0;
					phase = PH_CLASS;
				end else begin
					phase = PH_SYNC1;
				end
			end
			PH_CLASS: begin
				add_sum(b);
				cls = b;
				phase = PH_ID;
			end
			PH_ID: begin
				add_sum(b);
				id = b;
				count = '0;
				phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				add_sum(b);
				if (count == 0) begin
					len = {8'h00, b};
					count = 16'd1;
				end else begin
					count = '0;
					len[15:8] = b;
					if (len > MAX_LEN) begin
						phase = PH_SYNC1;
						emit(ubx_pkg::KIND_END, 8'h00, 8'h00, ubx_pkg::STATUS_TOO_LONG);
					end else begin
						phase = (len == 0) ? PH_CKA : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				add_sum(b);
				emit(ubx_pkg::KIND_PAYLOAD, b, count[7:0], ubx_pkg::STATUS_GOOD);
				count = count + 16'd1;
				if (count >= len) begin
					count = '0;
					phase = PH_CKA;
				end
			end
			PH_CKA: begin
				if (b != sum_a) begin
					phase = PH_SYNC1;
					emit(ubx_pkg::KIND_END, 8'h00, 8'h00, ubx_pkg::STATUS_BAD_CKA);
				end else begin
					phase = PH_CKB;
				end
			end
			default: begin
				phase = PH_SYNC1;
				emit(ubx_pkg::KIND_END, 8'h00, 8'h00,
					(b == sum_b) ? ubx_pkg::STATUS_GOOD : ubx_pkg::STATUS_BAD_CKB);
			end
		endcase
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task compare_field(string name, int got, int want);
		if (got != want)
			report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	task check_result(ubx_pkg::ubx_result_t got);
		ubx_pkg::ubx_result_t want;
		if (frame_results_q.size() == 0) begin
			report($sformatf("unexpected result 0x%0h", got));
		end else begin
			want = frame_results_q.pop_front();
			compare_field("kind", got.kind, want.kind);
			compare_field("data_byte", got.data_byte, want.data_byte);
			compare_field("byte_index", got.byte_index, want.byte_index);
			compare_field("frame_class", got.frame_class, want.frame_class);
			compare_field("msg_id", got.msg_id, want.msg_id);
			compare_field("frame_length", got.frame_length, want.frame_length);
			compare_field("status", got.status, want.status);
			compare_field("last", got.last, want.last);
		end
	endtask
endclass

module testbench;
	import ubx_pkg::*;

	localparam int MAX_PAYLOAD = 256;
	localparam int ITEMS = 1150;
	localparam int LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	localparam int DAMAGE_NONE = 0;
	localparam int DAMAGE_CKA  = 1;
	localparam int DAMAGE_CKB  = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  data_byte;
	logic [7:0]  byte_index;
	logic [7:0]  frame_class;
	logic [7:0]  msg_id;
	logic [15:0] frame_length;
	logic [1:0]  status;
	logic        last;

	frame_scoreboard #(MAX_PAYLOAD) sb;
	logic [7:0] rx_stream[$];
	logic [7:0] payload_q[$];
	int total;
	int sent = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit hold_done = 1'b0;

	ubx_frame_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result({kind, data_byte, byte_index, frame_class, msg_id,
				frame_length, status, last});

	// Append one frame; the payload comes from payload_q, which is consumed.
	task automatic add_frame(input logic [7:0] c, input logic [7:0] i,
		input logic [15:0] n, input int damage);
		logic [7:0] hdr[4];
		logic [7:0] a;
		logic [7:0] bsum;
		a = '0;
		bsum = '0;
		hdr = '{c, i, n[7:0], n[15:8]};
		rx_stream.push_back(SYNC_FIRST);
		rx_stream.push_back(SYNC_SECOND);
		foreach (hdr[k]) begin
			rx_stream.push_back(hdr[k]);
			a = a + hdr[k];
			bsum = bsum + a;
		end
		if (n > MAX_PAYLOAD) begin
			payload_q.delete();
			return;
		end
		foreach (payload_q[k]) begin
			rx_stream.push_back(payload_q[k]);
			a = a + payload_q[k];
			bsum = bsum + a;
		end
		payload_q.delete();
		if (damage == DAMAGE_CKA) begin
			// drop CK_B so the next sync byte follows the bad CK_A directly
			rx_stream.push_back(a ^ 8'($urandom_range(1, 255)));
			return;
		end
		rx_stream.push_back(a);
		if (damage == DAMAGE_CKB)
			bsum = bsum ^ 8'($urandom_range(1, 255));
		rx_stream.push_back(bsum);
	endtask

	task automatic build_stream();
		int r;
		int n;
		int k;
		logic [7:0] junk;
		// second 0xB5 breaks the sync and is not taken as a fresh first sync byte
		rx_stream.push_back(SYNC_FIRST);
		rx_stream.push_back(SYNC_FIRST);
		rx_stream.push_back(SYNC_SECOND);
		add_frame(8'hFF, 8'h00, 16'd0, DAMAGE_CKA);
		payload_q = '{8'h00, 8'hFF};
		add_frame(8'h00, 8'hFF, 16'd2, DAMAGE_CKB);
		add_frame(8'h5A, 8'hA5, 16'(MAX_PAYLOAD + 1), DAMAGE_NONE);
		add_frame(8'h01, 8'h07, 16'd0, DAMAGE_NONE);

		repeat (MAX_PAYLOAD) payload_q.push_back(8'($urandom));
		add_frame(8'($urandom), 8'($urandom), 16'(MAX_PAYLOAD), DAMAGE_NONE);

		while (rx_stream.size() < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom));
			end else if (r < 10) begin
				junk = 8'($urandom);
				if (junk == SYNC_SECOND)
					junk = SYNC_FIRST;
				rx_stream.push_back(SYNC_FIRST);
				rx_stream.push_back(junk);
			end else if (r < 18) begin
				add_frame(8'($urandom), 8'($urandom),
					16'($urandom_range(MAX_PAYLOAD + 1, 65535)), DAMAGE_NONE);
			end else begin
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 80)
					: $urandom_range(0, 16);
				repeat (n) payload_q.push_back(8'($urandom));
				k = $urandom_range(0, 9);
				add_frame(8'($urandom), 8'($urandom), 16'(n),
					(k == 0) ? DAMAGE_CKA : (k == 1) ? DAMAGE_CKB : DAMAGE_NONE);
			end
		end
	endtask

	// Offer one request and hold it until accepted.
	task automatic push_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
	endtask

	initial begin
		wait (arst_n);
		forever begin
			if (!hold_done && sent >= total / 2) begin
				// long hold-off while requests keep coming, so the parser backs up
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		int i;
		sb = new();
		build_stream();
		total = rx_stream.size();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < total; i++) begin
			calm = (i >= total * 9 / 10);
			if (!calm && $urandom_range(0, 6) == 0) begin
				in_valid <= 1'b0;
				rx_byte <= 8'($urandom);
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			push_byte(rx_stream[i]);
			sent = i + 1;
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
